// ===== sv/sobel_pkg.sv =====
`timescale 1ns / 1ps
package sobel_pkg;

  localparam int PixW   = 8;
  localparam int CoordW = 10;
  localparam int SizeW  = 11;
  localparam int CordicSteps = 14;

  // configuration register indexes
  localparam logic [1:0] RegWidth     = 2'd0;
  localparam logic [1:0] RegHeight    = 2'd1;
  localparam logic [1:0] RegThreshold = 2'd2;

  // cordic arctangent table, one full turn is 65536
  function automatic logic signed [17:0] atan_unit(input logic [3:0] i);
    case (i)
      4'd0:  atan_unit = 18'sd8192;
      4'd1:  atan_unit = 18'sd4836;
      4'd2:  atan_unit = 18'sd2555;
      4'd3:  atan_unit = 18'sd1297;
      4'd4:  atan_unit = 18'sd651;
      4'd5:  atan_unit = 18'sd326;
      4'd6:  atan_unit = 18'sd163;
      4'd7:  atan_unit = 18'sd81;
      4'd8:  atan_unit = 18'sd41;
      4'd9:  atan_unit = 18'sd20;
      4'd10: atan_unit = 18'sd10;
      4'd11: atan_unit = 18'sd5;
      4'd12: atan_unit = 18'sd3;
      4'd13: atan_unit = 18'sd1;
      default: atan_unit = 18'sd0;
    endcase
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_GRAD,
    ST_CORDIC,
    ST_DIR,
    ST_EMIT
  } state_t;

endpackage

// ===== sv/sobel_ram.sv =====
`timescale 1ns / 1ps
module sobel_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/sobel_edge_magnitude_direction_top.sv =====
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                      | tuser
// s_axis  | in  | pixel[7:0]                              | frame_start
// m_axis  | out | out_row[9:0] out_col[19:10] magnitude[27:20]
//         |     | direction[35:28], zero fill to 40        | frame_done ; tlast = run_last
// cfg     | in  | cfg_index[1:0], cfg_data[10:0]
// An interior pixel passes the accept, one line store read, one gradient step,
// 14 cordic iterations of one shared set of add/subtract units, one direction
// scaling step and then its result transfers (1 to 4).
// Pixels that form no result pass only the accept and the line store read;
// pixels outside the frame are only accepted. Reset is synchronous; line stores
// are not cleared. A stalled m_axis holds the result and blocks new input.
module sobel_edge_magnitude_direction_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_row, out_col, magnitude, direction
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser,   // frame_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [sobel_pkg::SizeW-1:0] cfg_data
);
  import sobel_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PW = (AW > $clog2(MAX_HEIGHT) ? AW : $clog2(MAX_HEIGHT)) + 1;

  logic [SizeW-1:0] image_width, image_height;
  logic [7:0]       threshold;

  state_t state, state_next;
  logic [PW-1:0] row, col, w, h, rr, cc;
  logic [7:0]  pix;
  logic [7:0]  win [3][3];
  logic        final_px;
  logic signed [11:0] sx, sy;
  logic [7:0]  mag;
  logic signed [19:0] cx, cy;
  logic signed [17:0] cz;
  logic [3:0]  step;
  logic [25:0] prod;
  logic [7:0]  dir;
  logic [1:0]  nr, nc, ra, cb;
  logic [2:0]  cnt;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SizeW'(640);
      image_height <= SizeW'(480);
      threshold    <= 8'd75;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegWidth:     image_width  <= cfg_data;
        RegHeight:    image_height <= cfg_data;
        RegThreshold: threshold    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // clamp sizes
  always_comb begin
    if (image_width < SizeW'(3)) w = PW'(3);
    else if (32'(image_width) > MAX_WIDTH) w = PW'(MAX_WIDTH);
    else w = PW'(image_width);
    if (image_height < SizeW'(3)) h = PW'(3);
    else if (32'(image_height) > MAX_HEIGHT) h = PW'(MAX_HEIGHT);
    else h = PW'(image_height);
  end

  logic in_xfer, in_frame;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  logic [PW-1:0] r_in, c_in;
  assign r_in = s_axis_tuser ? '0 : row;
  assign c_in = s_axis_tuser ? '0 : col;
  assign in_frame = (c_in < w) && (r_in < h);

  // line stores: read on accept, write back next cycle
  logic [AW-1:0] addr;
  logic [7:0]    up_rd, lo_rd;
  logic          st_we;
  assign st_we = (state == ST_READ);
  sobel_ram #(.Width(8), .Depth(MAX_WIDTH)) u_upper (
    .clk(clk), .we(st_we), .waddr(addr), .wdata(lo_rd),
    .raddr(c_in[AW-1:0]), .rdata(up_rd));
  sobel_ram #(.Width(8), .Depth(MAX_WIDTH)) u_lower (
    .clk(clk), .we(st_we), .waddr(addr), .wdata(pix),
    .raddr(c_in[AW-1:0]), .rdata(lo_rd));

  // cordic step
  logic signed [19:0] dx, dy;
  assign dx = cx >>> step;
  assign dy = cy >>> step;

  logic emit_xfer;
  assign emit_xfer = m_axis_tvalid && m_axis_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_xfer && in_frame) state_next = ST_READ;
      ST_READ:   state_next = (rr >= PW'(2) && cc >= PW'(2)) ? ST_GRAD : ST_IDLE;
      ST_GRAD:   state_next = ST_CORDIC;
      ST_CORDIC: if (step == 4'(CordicSteps - 1)) state_next = ST_DIR;
      ST_DIR:    state_next = ST_EMIT;
      ST_EMIT:   if (emit_xfer && cnt == 3'd1) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // position counters and window
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win[i][j] <= '0;
    end else begin
      if (in_xfer) begin
        if (c_in + PW'(1) >= w) begin
          col <= '0;
          row <= (r_in + PW'(1) >= h) ? '0 : r_in + PW'(1);
        end else begin
          col <= c_in + PW'(1);
          row <= r_in;
        end
        rr   <= r_in;
        cc   <= c_in;
        pix  <= s_axis_tdata;
        addr <= c_in[AW-1:0];
      end
      if (state == ST_READ) begin
        for (int i = 0; i < 3; i++) begin
          win[i][0] <= win[i][1];
          win[i][1] <= win[i][2];
        end
        win[0][2] <= up_rd;
        win[1][2] <= lo_rd;
        win[2][2] <= pix;
      end
    end
  end

  // datapath: gradient, cordic, direction scale, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      unique case (state)
        ST_READ: begin
          final_px <= (rr == h - PW'(1)) && (cc == w - PW'(1));
        end
        ST_GRAD: begin
          // window here already shifted: columns 0..2 are win[*][0..2]
          sx <= 12'(win[0][2]) + 12'({win[1][2], 1'b0}) + 12'(win[2][2])
              - 12'(win[0][0]) - 12'({win[1][0], 1'b0}) - 12'(win[2][0]);
          sy <= 12'(win[2][0]) + 12'({win[2][1], 1'b0}) + 12'(win[2][2])
              - 12'(win[0][0]) - 12'({win[0][1], 1'b0}) - 12'(win[0][2]);
          step <= '0;
        end
        ST_CORDIC: begin
          step <= step + 4'd1;
        end
        default: ;
      endcase
      if (state == ST_EMIT && emit_xfer) cnt <= cnt - 3'd1;
      if (state == ST_DIR)
        cnt <= (4'(nr) * 4'(nc) > 4'd4) ? 3'd4 : 3'(4'(nr) * 4'(nc));
    end
  end

  // cordic registers: loaded on first iteration from sx/sy
  logic [7:0] mag_c;
  logic signed [12:0] abx, aby;
  always_comb begin
    abx = sx[11] ? -13'(sx) : 13'(sx);
    aby = sy[11] ? -13'(sy) : 13'(sy);
    mag_c = (abx + aby > 13'sd255) ? 8'd255 : 8'(abx + aby);
  end

  logic special;
  logic signed [17:0] zspecial;
  always_comb begin
    special = 1'b0;
    zspecial = '0;
    if (sy == 0) begin
      special = 1'b1;
      zspecial = sx[11] ? 18'sd32768 : 18'sd0;
    end else if (sx == 0) begin
      special = 1'b1;
      zspecial = sy[11] ? -18'sd16384 : 18'sd16384;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_GRAD) begin
      cz <= '0;
    end else if (state == ST_CORDIC) begin
      if (step == 4'd0) begin
        // pre-rotation and first step together would chain; do pre-rotate
        // into the first iteration operands directly
        mag <= mag_c;
      end
      if (step == 4'd0) begin
        logic signed [19:0] x0, y0;
        logic signed [17:0] z0;
        x0 = '0; y0 = '0; z0 = '0;
        if (sx[11]) begin
          if (!sy[11]) begin z0 = 18'sd16384; x0 = 20'(sy) <<< 8; y0 = -(20'(sx) <<< 8); end
          else begin z0 = -18'sd16384; x0 = -(20'(sy) <<< 8); y0 = 20'(sx) <<< 8; end
        end else begin
          x0 = 20'(sx) <<< 8; y0 = 20'(sy) <<< 8;
        end
        if (!y0[19]) begin cx <= x0 + y0; cy <= y0 - x0; cz <= z0 + atan_unit(4'd0); end
        else begin cx <= x0 - y0; cy <= y0 + x0; cz <= z0 - atan_unit(4'd0); end
      end else begin
        if (!cy[19]) begin cx <= cx + dy; cy <= cy - dx; cz <= cz + atan_unit(step); end
        else begin cx <= cx - dy; cy <= cy + dx; cz <= cz - atan_unit(step); end
      end
    end
  end

  // direction scaling
  logic signed [17:0] zc;
  logic [16:0] zoff;
  always_comb begin
    zc = special ? zspecial : cz;
    if (zc > 18'sd32768) zc = 18'sd32768;
    if (zc < -18'sd32768) zc = -18'sd32768;
    zoff = 17'(zc + 18'sd32768);
    prod = 26'(zoff) * 26'd255 + 26'd655;
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIR) begin
      if (mag < threshold) dir <= 8'd0;
      else dir <= (prod[25:16] > 10'd255) ? 8'd255 : prod[23:16];
      ra <= '0;
      cb <= '0;
    end else if (state == ST_EMIT && emit_xfer) begin
      if (cb + 2'd1 >= nc) begin cb <= '0; ra <= ra + 2'd1; end
      else cb <= cb + 2'd1;
    end
  end

  // copy lists
  logic [PW-1:0] ir, ic, orow, ocol;
  assign ir = rr - PW'(1);
  assign ic = cc - PW'(1);
  always_comb begin
    nr = 2'd1 + 2'(ir == PW'(1)) + 2'(ir == h - PW'(2));
    nc = 2'd1 + 2'(ic == PW'(1)) + 2'(ic == w - PW'(2));
    orow = ir;
    if (ra == 2'd1) orow = (ir == PW'(1)) ? '0 : h - PW'(1);
    else if (ra == 2'd2) orow = h - PW'(1);
    ocol = ic;
    if (cb == 2'd1) ocol = (ic == PW'(1)) ? '0 : w - PW'(1);
    else if (cb == 2'd2) ocol = w - PW'(1);
  end

  assign m_axis_tvalid = (state == ST_EMIT);
  assign m_axis_tdata  = {4'd0, dir, mag, ocol[CoordW-1:0], orow[CoordW-1:0]};
  assign m_axis_tlast  = (cnt == 3'd1);
  assign m_axis_tuser  = (cnt == 3'd1) && final_px;

endmodule

// ===== sv/sobel_checker.sv =====
`timescale 1ns / 1ps
module sobel_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast,
  input logic m_axis_tuser
);
  // no input taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready while emitting");
  // frame_done only with run_last
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast) else $error("frame_done without last");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  // output idle right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid after reset");
endmodule

bind sobel_edge_magnitude_direction_top sobel_checker u_chk (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser));

// ===== dv/sobel_result_checker.sv =====
`timescale 1ns / 1ps
module sobel_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [sobel_pkg::SizeW-1:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);
  import sobel_pkg::*;

  localparam int MaxSize = 1024;
  localparam int AtanStep [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10,
                                   5, 3, 1};

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] col;
    logic [7:0] mag;
    logic [7:0] dir;
    logic       last;
    logic       done;
  } edge_result_t;

  edge_result_t expected_edges[$];

  // predictor state
  logic [7:0]  upper_line [MaxSize];
  logic [7:0]  lower_line [MaxSize];
  logic [7:0]  win [3][3];
  int          row_pos, col_pos;
  logic [10:0] width_reg, height_reg;
  logic [7:0]  thresh_reg;

  function automatic int clamp_size(input logic [10:0] v);
    if (v < 3) return 3;
    if (v > MaxSize) return MaxSize;
    return int'(v);
  endfunction

  // cordic vectoring, one full turn is 65536
  function automatic int gradient_angle(input int gx, input int gy);
    int x, y, z, dx, dy;
    z = 0;
    if (gy == 0) return (gx >= 0) ? 0 : 32768;
    if (gx == 0) return (gy > 0) ? 16384 : -16384;
    if (gx < 0) begin
      if (gy > 0) begin
        z = 16384; x = gy; y = -gx;
      end else begin
        z = -16384; x = -gy; y = gx;
      end
    end else begin
      x = gx; y = gy;
    end
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < 14; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy; y -= dx; z += AtanStep[i];
      end else begin
        x -= dy; y += dx; z -= AtanStep[i];
      end
    end
    if (z > 32768) z = 32768;
    if (z < -32768) z = -32768;
    return z;
  endfunction

  task automatic predict_pixel(input logic [7:0] pix, input logic fs);
    int w, h, r, c, gx, gy, mag, dir, nr, nc, n;
    int rows [3];
    int cols [3];
    logic [7:0] top, mid;
    edge_result_t e;
    edge_result_t batch[$];
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    if (c < w && r < h) begin
      top = upper_line[c];
      mid = lower_line[c];
      upper_line[c] = mid;
      lower_line[c] = pix;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = pix;
      if (r >= 2 && c >= 2) begin
        gx = win[0][2] + 2 * win[1][2] + win[2][2] - win[0][0] - 2 * win[1][0] - win[2][0];
        gy = win[2][0] + 2 * win[2][1] + win[2][2] - win[0][0] - 2 * win[0][1] - win[0][2];
        mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
        if (mag > 255) mag = 255;
        dir = ((gradient_angle(gx, gy) + 32768) * 255 + 655) >>> 16;
        if (dir > 255) dir = 255;
        if (mag < thresh_reg) dir = 0;
        // border copies go out together with their interior source
        nr = 0; nc = 0;
        rows[nr++] = r - 1;
        if (r - 1 == 1) rows[nr++] = 0;
        if (r - 1 == h - 2) rows[nr++] = h - 1;
        cols[nc++] = c - 1;
        if (c - 1 == 1) cols[nc++] = 0;
        if (c - 1 == w - 2) cols[nc++] = w - 1;
        n = 0;
        for (int a = 0; a < nr; a++) begin
          for (int b = 0; b < nc; b++) begin
            if (n < 4) begin
              e.row  = 10'(rows[a]);
              e.col  = 10'(cols[b]);
              e.mag  = 8'(mag);
              e.dir  = 8'(dir);
              e.last = 1'b0;
              e.done = 1'b0;
              batch.push_back(e);
              n++;
            end
          end
        end
        batch[n-1].last = 1'b1;
        batch[n-1].done = (r == h - 1) && (c == w - 1);
        foreach (batch[k]) expected_edges.push_back(batch[k]);
      end
    end
    c = c + 1;
    if (c >= w) begin
      c = 0;
      r = r + 1;
      if (r >= h) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  task automatic compare_result();
    edge_result_t e, got;
    got.row  = m_axis_tdata[9:0];
    got.col  = m_axis_tdata[19:10];
    got.mag  = m_axis_tdata[27:20];
    got.dir  = m_axis_tdata[35:28];
    got.last = m_axis_tlast;
    got.done = m_axis_tuser;
    if (expected_edges.size() == 0) begin
      $display("%0t: unexpected result row %0d col %0d mag %0d dir %0d", $realtime,
               got.row, got.col, got.mag, got.dir);
      mismatches++;
      return;
    end
    e = expected_edges.pop_front();
    if (got !== e) begin
      $display("%0t: result mismatch, expected row %0d col %0d mag %0d dir %0d last %0b done %0b",
               $realtime, e.row, e.col, e.mag, e.dir, e.last, e.done);
      $display("%0t:                    actual row %0d col %0d mag %0d dir %0d last %0b done %0b",
               $realtime, got.row, got.col, got.mag, got.dir, got.last, got.done);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
  end

  // watch every channel at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      foreach (win[i, j]) win[i][j] = '0;
      row_pos    = 0;
      col_pos    = 0;
      width_reg  = 11'd640;
      height_reg = 11'd480;
      thresh_reg = 8'd75;
      expected_edges.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegWidth:     width_reg  = cfg_data;
          RegHeight:    height_reg = cfg_data;
          RegThreshold: thresh_reg = cfg_data[7:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) compare_result();
      if (s_axis_tvalid && s_axis_tready) predict_pixel(s_axis_tdata, s_axis_tuser);
    end
    outstanding = expected_edges.size();
  end

endmodule

// ===== dv/sobel_edge_magnitude_direction_top_test.sv =====
`timescale 1ns / 1ps
module sobel_edge_magnitude_direction_top_test;
  import sobel_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 40;
  localparam int RandomPixels  = 300;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [SizeW-1:0] cfg_data;

  int mismatches, outstanding;
  int burst_left;
  int pixels_sent;
  int idle_cycles;
  int stall_phase;

  sobel_edge_magnitude_direction_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sobel_result_checker edge_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // result side stall pattern, mode picked by bits 8:7 of the phase counter
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    case (stall_phase[8:7])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2: m_axis_tready <= (stall_phase % 5) < 2;
      default: m_axis_tready <= $urandom_range(0, 3) != 0;
    endcase
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired", $realtime);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one pixel transfer, sender works in bursts with random gaps
  task automatic send_pixel(input logic [7:0] pix, input logic fs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= fs;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    pixels_sent++;
  endtask

  // all expected results in, then let the block finish any silent pixel
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [SizeW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input int w, input int h, input int thr);
    wait_idle();
    write_reg(RegWidth, SizeW'(w));
    write_reg(RegHeight, SizeW'(h));
    write_reg(RegThreshold, SizeW'(thr));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] random_pixel(input int style, input int r, input int c);
    case (style)
      0: return 8'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return 8'((r * 23 + c * 41 + $urandom_range(0, 15)) & 8'hff);
    endcase
  endfunction

  // directed 3x3 images: flat, edges pointing right, left and up
  function automatic logic [7:0] pattern_pixel(input int kind, input int r, input int c);
    case (kind)
      0: return 8'd128;
      1: return (c == 2) ? 8'd255 : 8'd0;
      2: return (c == 0) ? 8'd255 : 8'd0;
      default: return (r == 0) ? 8'd255 : 8'd0;
    endcase
  endfunction

  task automatic send_frames(input int w, input int h, input int frames, input int style,
                             input bit noise);
    logic fs;
    for (int f = 0; f < frames; f++) begin
      for (int r = 0; r < h; r++) begin
        for (int c = 0; c < w; c++) begin
          fs = (f == 0 && r == 0 && c == 0) ||
               (noise && r > 0 && $urandom_range(0, 60) == 0);
          send_pixel(random_pixel(style, r, c), fs);
        end
      end
    end
  endtask

  initial begin
    int w, h, thr;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = RegWidth;
    cfg_data      = '0;
    burst_left    = 0;
    pixels_sent   = 0;
    idle_cycles   = 0;
    stall_phase   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // narrow frames, later ones start by wrapping without a start mark
    configure(3, 3, 0);
    for (int k = 0; k < 4; k++)
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          send_pixel(pattern_pixel(k, r, c), k == 0 && r == 0 && c == 0);

    // size clamping at both ends, wide row kept short
    configure(2047, 3, 255);
    for (int i = 0; i < 24; i++) send_pixel(random_pixel(0, 0, i), i == 0);
    configure(0, 2047, 128);
    send_frames(3, 12, 1, 1, 1'b0);

    // shrink the width mid-frame, then the height
    configure(8, 6, 40);
    for (int i = 0; i < 21; i++) send_pixel(random_pixel(0, 0, 0), i == 0);
    configure(4, 6, 40);
    for (int i = 0; i < 12; i++) send_pixel(random_pixel(2, i / 4, i % 4), 1'b0);
    configure(4, 3, 40);
    for (int i = 0; i < 20; i++) send_pixel(random_pixel(0, 0, 0), 1'b0);

    // random frame sizes and thresholds
    pixels_sent = 0;
    while (pixels_sent < RandomPixels) begin
      w = $urandom_range(3, 9);
      h = $urandom_range(3, 7);
      case ($urandom_range(0, 3))
        0: thr = 0;
        1: thr = 255;
        default: thr = $urandom_range(0, 255);
      endcase
      configure(w, h, thr);
      send_frames(w, h, $urandom_range(1, 3), $urandom_range(0, 2), $urandom_range(0, 3) == 0);
    end

    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
